// File: hw/rtl/shs_pkg.sv
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_message;
  } shs_in_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } shs_out_t;

  // commands from the sequencer to the compression unit
  typedef struct packed {
    logic       init;
    logic       start;
    logic       load_en;
    logic [7:0] load_byte;
  } shs_cmp_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_PAD,
    ST_EMIT
  } shs_state_e;

  localparam int unsigned BlockBytes = 64;
  localparam logic [5:0]  LastSlot   = 6'd63;
  localparam logic [5:0]  LenSlot    = 6'd56;
  localparam logic [7:0]  PadMarker  = 8'h80;
  localparam logic [63:0] BlockBits  = 64'd512;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: hw/rtl/shs_front.sv
module shs_front import shs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  shs_in_t in_item_i,
  output logic    item_valid_o,
  output shs_in_t item_o,
  input  logic    item_pop_i
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);

  shs_in_t           mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              accept, keep, do_wr, do_rd;

  assign full   = (count_q == FullCount);
  assign accept = push && !full;
  // an absent byte without finish changes nothing, so it is dropped here
  assign keep   = in_item_i.byte_present || in_item_i.last_of_message;
  assign do_wr  = accept && keep;
  assign do_rd  = item_pop_i && item_valid_o;

  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: hw/rtl/shs_compress.sv
module shs_compress import shs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  shs_cmp_ctrl_t ctrl_i,
  output logic          done_o,
  output logic [255:0]  hash_o
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [511:0] win_q, win_d;
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [31:0]  h_q [8];
  logic [31:0]  h_d [8];
  logic [5:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d;
  logic         add_q, add_d;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, big_e, big_a, choose, major, t1, t2;

  // window holds the 16 newest schedule words, oldest at the top
  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];

  assign s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign big_e  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1     = v_q[7] + big_e + choose + RoundK[rnd_q] + w0;
  assign big_a  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2     = big_a + major;

  always_comb begin
    win_d  = win_q;
    v_d    = v_q;
    h_d    = h_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    add_d  = 1'b0;
    if (ctrl_i.load_en) begin
      win_d = {win_q[503:0], ctrl_i.load_byte};
    end
    if (ctrl_i.start) begin
      v_d    = h_q;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      win_d = {win_q[479:0], w_new};
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      rnd_d  = rnd_q + 1'b1;
      if (rnd_q == LastSlot) begin
        busy_d = 1'b0;
        add_d  = 1'b1;
      end
    end
    if (add_q) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end
    if (ctrl_i.init) begin
      h_d = InitHash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      rnd_q  <= '0;
      h_q    <= InitHash;
    end else begin
      busy_q <= busy_d;
      add_q  <= add_d;
      rnd_q  <= rnd_d;
      h_q    <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

  assign done_o = add_q;
  assign hash_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule

// File: hw/rtl/shs_back.sv
module shs_back import shs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  shs_in_t       item_i,
  output logic          item_pop_o,
  output shs_cmp_ctrl_t cmp_ctrl_o,
  input  logic          cmp_done_i,
  input  logic          out_ready_i,
  output logic          emit_o
);

  shs_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        first_q, first_d;
  logic        len_q, len_d;
  logic        fin_q, fin_d;
  logic        final_q, final_d;
  logic        len_now;
  logic [7:0]  pad_byte;

  // length field starts at byte 56 unless the marker byte itself lands there
  assign len_now = len_q || (!first_q && (fill_q == LenSlot));

  always_comb begin
    if (first_q) begin
      pad_byte = PadMarker;
    end else if (len_now) begin
      pad_byte = total_q[63 - 8 * fill_q[2:0] -: 8];
    end else begin
      pad_byte = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          if (item_i.byte_present && (fill_q == LastSlot)) begin
            state_d = ST_START;
          end else if (item_i.last_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (cmp_done_i) begin
          if (final_q) begin
            state_d = ST_EMIT;
          end else if (fin_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == LastSlot) begin
          state_d = ST_START;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop_o = 1'b0;
    cmp_ctrl_o = '0;
    emit_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_pop_o           = item_valid_i;
        cmp_ctrl_o.load_en   = item_valid_i && item_i.byte_present;
        cmp_ctrl_o.load_byte = item_i.data_byte;
      end
      ST_START: cmp_ctrl_o.start = 1'b1;
      ST_PAD: begin
        cmp_ctrl_o.load_en   = 1'b1;
        cmp_ctrl_o.load_byte = pad_byte;
      end
      ST_EMIT: begin
        emit_o          = out_ready_i;
        cmp_ctrl_o.init = out_ready_i;
      end
      default: ;
    endcase
  end

  // counters and message bookkeeping
  always_comb begin
    fill_d  = fill_q;
    bits_d  = bits_q;
    total_d = total_q;
    first_d = first_q;
    len_d   = len_q;
    fin_d   = fin_q;
    final_d = final_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          fin_d   = item_i.last_of_message;
          first_d = 1'b1;
          len_d   = 1'b0;
          final_d = 1'b0;
          if (item_i.byte_present) begin
            fill_d = fill_q + 1'b1;
            if (fill_q == LastSlot) begin
              bits_d = bits_q + BlockBits;
            end
          end
        end
      end
      ST_PAD: begin
        fill_d  = fill_q + 1'b1;
        first_d = 1'b0;
        fin_d   = 1'b1;
        len_d   = len_now;
        if (first_q) begin
          total_d = bits_q + {55'd0, fill_q, 3'd0};
        end
        if (fill_q == LastSlot) begin
          final_d = len_now;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          fill_d = '0;
          bits_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      first_q <= first_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

endmodule

// File: hw/rtl/sha256_stream_hasher.sv
// SHA-256 hasher fed one item per push. An item carries a message byte, a
// byte_present flag and last_of_message. Items enter a small queue (full
// rises when it holds QueueDepth items); items with neither a byte nor a
// finish are dropped there.
// The back end shifts one byte per cycle into a 512-bit block window while
// it is not padding or waiting on a compression. The 64th byte starts the
// compression: a start step, 64 rounds at one per cycle, then the hash
// update. The single round unit shares the window with the loader, so no
// byte is taken until the block is done.
// A finishing item pads one byte per cycle, pausing for the first
// compression when a second block is needed (up to 64 bytes, or 72 with a
// second block), runs one or two compressions, then places the digest
// (H0..H7 as four big-endian 64-bit words) in the result register.
// A result waits there while empty is low until pop takes it; while it waits
// the hasher stalls before the next digest and the input queue keeps taking
// items until it fills. After reset the hash holds the initial values, the
// block is empty, the bit count is zero, and the input queue and the result
// register are empty; each digest restores the hash, block and bit count.
module sha256_stream_hasher import shs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  shs_in_t  in_item_i,
  output logic     empty,
  input  logic     pop,
  output shs_out_t out_item_o
);

  logic          item_valid, item_pop;
  shs_in_t       item;
  shs_cmp_ctrl_t cmp_ctrl;
  logic          cmp_done;
  logic [255:0]  hash;
  logic          out_ready, emit;
  logic          out_valid_q, out_valid_d;
  shs_out_t      out_q;

  shs_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  shs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cmp_ctrl_o   (cmp_ctrl),
    .cmp_done_i   (cmp_done),
    .out_ready_i  (out_ready),
    .emit_o       (emit)
  );

  shs_compress u_compress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .done_o (cmp_done),
    .hash_o (hash)
  );

  assign out_ready = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= hash;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

// File: tb/sv/tb_sha256_stream_hasher.sv
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
  import shs_pkg::*;

  localparam int ItemTarget  = 1650;
  localparam int StallLimit  = 20000;
  localparam int DrainCycles = 600;
  localparam int DirCount    = 16;

  localparam int SendIdlePct [4] = '{0, 74, 0, 20};
  localparam int RecvStallPct[4] = '{0, 0, 74, 20};

  // lengths around the padding boundaries
  localparam int EdgeLens[12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] StartHash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    shs_in_t  item;
    logic     ref_ok;
    shs_out_t ref_dg;
  } dir_row_t;

  // fields: data_byte, byte_present, last_of_message, known digest flag, digest
  localparam dir_row_t DirRows[DirCount] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    {8'h55, 1'b0, 1'b0, 1'b0, 256'h0},
    {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'haa, 1'b0, 1'b1, 1'b0, 256'h0},
    {8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    {8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    {8'h5a, 1'b0, 1'b1, 1'b1, EmptyDigest},
    {8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    {8'ha5, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h5a, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
    {8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest}
  };

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     push      = 1'b0;
  logic     full;
  shs_in_t  in_item_i = '0;
  logic     empty;
  logic     pop       = 1'b0;
  shs_out_t out_item_o;

  sha256_stream_hasher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hash state tracked alongside the block
  logic [31:0] hash_st[8];
  logic [7:0]  blk_buf[64];
  int unsigned fill_cnt;
  logic [63:0] bit_total;

  shs_out_t pending_digests[$];
  int       error_count = 0;
  int       idle_mode   = 0;
  int       quiet_cycles = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int k = 0; k < 8; k++) hash_st[k] = StartHash[k];
    fill_cnt  = 0;
    bit_total = '0;
  endfunction

  function automatic void compress_buffer();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + RoundConst[t] + w[t];
      s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  // absorb one accepted item; a finish pads, closes and yields the digest
  function automatic void hash_item(input shs_in_t it, output bit done, output shs_out_t dg);
    logic [63:0] msg_len;
    int          pos;
    done = 1'b0;
    dg   = '0;
    if (it.byte_present) begin
      blk_buf[fill_cnt] = it.data_byte;
      fill_cnt++;
      if (fill_cnt == 64) begin
        compress_buffer();
        bit_total += 64'd512;
        fill_cnt = 0;
      end
    end
    if (!it.last_of_message) return;
    msg_len = bit_total + 64'(fill_cnt) * 64'd8;
    pos = fill_cnt;
    blk_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      // length does not fit: flush this block and pad a second one
      while (pos < 64) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      compress_buffer();
      pos = 0;
    end
    while (pos < 56) begin
      blk_buf[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) blk_buf[56 + k] = msg_len[63 - 8*k -: 8];
    compress_buffer();
    dg = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
          hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    done = 1'b1;
    restart_hash();
  endfunction

  task automatic send_item(input shs_in_t it, input bit use_ref, input shs_out_t ref_dg);
    bit       done;
    shs_out_t dg;
    while (SendIdlePct[idle_mode] != 0 && $urandom_range(0, 99) < SendIdlePct[idle_mode]) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    hash_item(it, done, dg);
    if (done) pending_digests.push_back(use_ref ? ref_dg : dg);
  endtask

  function automatic void check_word(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (error_count < 10) begin
        $display("%0t: %s differs: expected %h, got %h", $time, name, want, got);
      end
      error_count++;
    end
  endfunction

  // result side: random pop, compare each accepted digest with the oldest one due
  always @(posedge clk_i) begin
    shs_out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_digests.size() == 0) begin
        if (error_count < 10) begin
          $display("%0t: digest with none outstanding: %h", $time, out_item_o);
        end
        error_count++;
      end else begin
        want = pending_digests.pop_front();
        check_word("digest_word0", want.digest_word0, out_item_o.digest_word0);
        check_word("digest_word1", want.digest_word1, out_item_o.digest_word1);
        check_word("digest_word2", want.digest_word2, out_item_o.digest_word2);
        check_word("digest_word3", want.digest_word3, out_item_o.digest_word3);
      end
    end
    pop <= ($urandom_range(0, 99) >= RecvStallPct[idle_mode]);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shs_in_t it;
    int      counted;
    int      len;
    bit      fin_with_byte;
    counted = 0;
    restart_hash();
    for (int k = 0; k < 64; k++) blk_buf[k] = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirCount; r++) begin
      send_item(DirRows[r].item, DirRows[r].ref_ok, DirRows[r].ref_dg);
    end

    while (counted < ItemTarget) begin
      idle_mode = (counted * 4) / ItemTarget;
      if ($urandom_range(0, 3) == 0) len = EdgeLens[$urandom_range(0, 11)];
      else len = $urandom_range(0, 70);
      fin_with_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // absent byte, no finish: dropped by the block
          it.data_byte       = 8'($urandom_range(0, 255));
          it.byte_present    = 1'b0;
          it.last_of_message = 1'b0;
          send_item(it, 1'b0, '0);
          counted++;
        end
        it.data_byte       = 8'($urandom_range(0, 255));
        it.byte_present    = 1'b1;
        it.last_of_message = fin_with_byte && (i == len - 1);
        send_item(it, 1'b0, '0);
        counted++;
      end
      if (!fin_with_byte) begin
        it.data_byte       = 8'($urandom_range(0, 255));
        it.byte_present    = 1'b0;
        it.last_of_message = 1'b1;
        send_item(it, 1'b0, '0);
        counted++;
      end
    end

    push      <= 1'b0;
    idle_mode = 0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && pending_digests.size() == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule

// File: sha256_stream_hasher.f
hw/rtl/shs_pkg.sv
hw/rtl/shs_front.sv
hw/rtl/shs_compress.sv
hw/rtl/shs_back.sv
hw/rtl/sha256_stream_hasher.sv
tb/sv/tb_sha256_stream_hasher.sv
